@@ rtl/dfs_pkg.sv @@
// dfs_pkg: shared types and constants for the detector frame sparsifier
// no dependencies; imported by every module of the block

package dfs_pkg;

  // field widths
  localparam int RAW_W   = 64;
  localparam int MASK_W  = 2;
  localparam int IDX_W   = 22;
  localparam int CNT_W   = 31;
  localparam int ADDR_W  = 32;
  localparam int FCNT_W  = 23;
  localparam int KIND_W  = 2;
  localparam int VT_W    = 3;

  // frame length and saturation limits
  localparam logic [IDX_W:0]    MAX_FRAME_PIXELS = 23'd4194304;
  localparam logic [FCNT_W-1:0] FCNT_MAX         = {FCNT_W{1'b1}};
  localparam logic [ADDR_W-1:0] ADDR_MAX         = {ADDR_W{1'b1}};

  // mask values below this mark a usable pixel
  localparam logic [MASK_W-1:0] MASK_LIMIT = 2'd2;

  // element type codes
  localparam logic [VT_W-1:0] VT_U8  = 3'd0;
  localparam logic [VT_W-1:0] VT_S8  = 3'd1;
  localparam logic [VT_W-1:0] VT_U16 = 3'd2;
  localparam logic [VT_W-1:0] VT_S16 = 3'd3;
  localparam logic [VT_W-1:0] VT_U32 = 3'd4;
  localparam logic [VT_W-1:0] VT_S32 = 3'd5;
  localparam logic [VT_W-1:0] VT_U64 = 3'd6;
  localparam logic [VT_W-1:0] VT_S64 = 3'd7;

  // record kinds
  localparam logic [KIND_W-1:0] KIND_SINGLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MULTI   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  // one accepted pixel transaction
  typedef struct packed {
    logic [RAW_W-1:0]  raw_word;
    logic [MASK_W-1:0] pixel_mask;
    logic              frame_end;
  } pix_t;

  // records produced by one pixel: an optional photon record and an
  // optional frame summary
  typedef struct packed {
    logic              has_photon;
    logic              is_multi;
    logic [IDX_W-1:0]  pixel_index;
    logic [CNT_W-1:0]  photon_count;
    logic [ADDR_W-1:0] list_address;
    logic              has_summary;
    logic [FCNT_W-1:0] frame_singles;
    logic [FCNT_W-1:0] frame_multis;
    logic [ADDR_W-1:0] next_single_offset;
    logic [ADDR_W-1:0] next_multi_offset;
  } rec_t;

  // 32-bit add that sticks at all ones
  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [FCNT_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {{(ADDR_W+1-FCNT_W){1'b0}}, b};
    return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
  endfunction

endpackage

@@ rtl/detector_frame_sparsifier.sv @@
// detector_frame_sparsifier: top level of the dense-to-sparse photon list encoder
// depends on dfs_pkg, dfs_in_reg, dfs_frame_state, dfs_out_reg
// a record is offered from the result register once its pixel has moved on from the input register
// throughput: one pixel per cycle while out_stall is low; a frame-end pixel that also holds photons
//   occupies the result register for its photon record and then its summary record
// reset: synchronous rst clears counters, list offsets and element type (u8)

module detector_frame_sparsifier (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dfs_pkg::VT_W-1:0]     value_type,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dfs_pkg::RAW_W-1:0]    raw_word,
  input  logic [dfs_pkg::MASK_W-1:0]   pixel_mask,
  input  logic                         frame_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dfs_pkg::KIND_W-1:0]   record_kind,
  output logic [dfs_pkg::IDX_W-1:0]    pixel_index,
  output logic [dfs_pkg::CNT_W-1:0]    photon_count,
  output logic [dfs_pkg::ADDR_W-1:0]   list_address,
  output logic [dfs_pkg::FCNT_W-1:0]   frame_singles,
  output logic [dfs_pkg::FCNT_W-1:0]   frame_multis,
  output logic [dfs_pkg::ADDR_W-1:0]   next_single_offset,
  output logic [dfs_pkg::ADDR_W-1:0]   next_multi_offset,
  output logic                         last_of_run
);
  import dfs_pkg::*;

  pix_t in_pix;
  pix_t pix;
  rec_t rec;
  logic full;
  logic load_ok;
  logic advance;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // pack the incoming transaction
  assign in_pix.raw_word   = raw_word;
  assign in_pix.pixel_mask = pixel_mask;
  assign in_pix.frame_end  = frame_end;

  // pixel moves on when the result register can take it
  assign advance = full && load_ok;

  dfs_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pix   (in_pix),
    .advance  (advance),
    .full     (full),
    .pix      (pix)
  );

  dfs_frame_state u_frame_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (value_type),
    .pix       (pix),
    .advance   (advance),
    .rec       (rec)
  );

  dfs_out_reg u_out_reg (
    .clk                (clk),
    .rst                (rst),
    .rec_in             (rec),
    .src_valid          (full),
    .load_ok            (load_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .record_kind        (record_kind),
    .pixel_index        (pixel_index),
    .photon_count       (photon_count),
    .list_address       (list_address),
    .frame_singles      (frame_singles),
    .frame_multis       (frame_multis),
    .next_single_offset (next_single_offset),
    .next_multi_offset  (next_multi_offset),
    .last_of_run        (last_of_run)
  );

endmodule

@@ rtl/dfs_in_reg.sv @@
// dfs_in_reg: input register stage holding one pixel transaction
// depends on dfs_pkg

module dfs_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dfs_pkg::pix_t in_pix,
  input  logic          advance,
  output logic          full,
  output dfs_pkg::pix_t pix
);
  import dfs_pkg::*;

  logic full_next;

  // stage is free when empty or being drained this cycle
  assign in_stall  = full && !advance;
  assign full_next = (in_valid && !in_stall) || (full && !advance);

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pix <= in_pix;
    end
  end

endmodule

@@ rtl/dfs_frame_state.sv @@
// dfs_frame_state: element decode, frame counters and list offsets
// depends on dfs_pkg; builds the records for the pixel in the input register

module dfs_frame_state (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dfs_pkg::VT_W-1:0]   cfg_value,
  input  dfs_pkg::pix_t              pix,
  input  logic                       advance,
  output dfs_pkg::rec_t              rec
);
  import dfs_pkg::*;

  logic [VT_W-1:0]   value_type;
  logic [IDX_W-1:0]  pixel_counter;
  logic [FCNT_W-1:0] singles_in_frame;
  logic [FCNT_W-1:0] multis_in_frame;
  logic [ADDR_W-1:0] single_list_offset;
  logic [ADDR_W-1:0] multi_list_offset;

  logic [31:0]       v;
  logic              used;
  logic              is_single;
  logic              is_multi;
  logic [IDX_W:0]    pc_inc;
  logic [IDX_W-1:0]  pixel_counter_next;
  logic [FCNT_W-1:0] singles_after;
  logic [FCNT_W-1:0] multis_after;
  logic [ADDR_W-1:0] ns;
  logic [ADDR_W-1:0] nm;

  // element type register
  always_ff @(posedge clk) begin
    if (rst) begin
      value_type <= VT_U8;
    end else if (cfg_we) begin
      value_type <= cfg_value;
    end
  end

  // decode to a 32-bit two's complement value
  always_comb begin
    case (value_type)
      VT_U8:   v = {24'd0, pix.raw_word[7:0]};
      VT_S8:   v = {{24{pix.raw_word[7]}}, pix.raw_word[7:0]};
      VT_U16:  v = {16'd0, pix.raw_word[15:0]};
      VT_S16:  v = {{16{pix.raw_word[15]}}, pix.raw_word[15:0]};
      default: v = pix.raw_word[31:0];
    endcase
  end

  // photon classification
  assign used      = (pix.pixel_mask < MASK_LIMIT) && !v[31] && (v != 32'd0);
  assign is_single = used && (v == 32'd1);
  assign is_multi  = used && (v != 32'd1);

  // counts including this pixel, then next list offsets
  assign singles_after = (is_single && singles_in_frame != FCNT_MAX)
                         ? singles_in_frame + 1'b1 : singles_in_frame;
  assign multis_after  = (is_multi && multis_in_frame != FCNT_MAX)
                         ? multis_in_frame + 1'b1 : multis_in_frame;
  assign ns = sat_add(single_list_offset, singles_after);
  assign nm = sat_add(multi_list_offset, multis_after);

  // pixel position wraps at the frame limit
  assign pc_inc             = {1'b0, pixel_counter} + 1'b1;
  assign pixel_counter_next = (pc_inc >= MAX_FRAME_PIXELS) ? '0 : pc_inc[IDX_W-1:0];

  // record build
  always_comb begin
    rec                    = '0;
    rec.has_photon         = used;
    rec.is_multi           = is_multi;
    rec.pixel_index        = pixel_counter;
    rec.photon_count       = v[CNT_W-1:0];
    rec.list_address       = is_multi ? sat_add(multi_list_offset, multis_in_frame)
                                      : sat_add(single_list_offset, singles_in_frame);
    rec.has_summary        = pix.frame_end;
    rec.frame_singles      = singles_after;
    rec.frame_multis       = multis_after;
    rec.next_single_offset = ns;
    rec.next_multi_offset  = nm;
  end

  // frame state update as the pixel leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter      <= '0;
      singles_in_frame   <= '0;
      multis_in_frame    <= '0;
      single_list_offset <= '0;
      multi_list_offset  <= '0;
    end else if (advance) begin
      if (pix.frame_end) begin
        pixel_counter      <= '0;
        singles_in_frame   <= '0;
        multis_in_frame    <= '0;
        single_list_offset <= ns;
        multi_list_offset  <= nm;
      end else begin
        pixel_counter    <= pixel_counter_next;
        singles_in_frame <= singles_after;
        multis_in_frame  <= multis_after;
      end
    end
  end

  // frame end leaves a clean frame
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    advance && pix.frame_end |=>
      pixel_counter == '0 && singles_in_frame == '0 && multis_in_frame == '0)
    else $error("frame counters not cleared after frame end");

  // list offsets never move backward
  a_offset_mono: assert property (@(posedge clk) disable iff (rst)
    advance |=> single_list_offset >= $past(single_list_offset) &&
                multi_list_offset >= $past(multi_list_offset))
    else $error("list offset decreased");

  // a pixel adds at most one photon to the frame counts
  a_one_photon: assert property (@(posedge clk) disable iff (rst)
    advance && !pix.frame_end |=>
      ({1'b0, singles_in_frame} + {1'b0, multis_in_frame}) <=
      ({1'b0, $past(singles_in_frame)} + {1'b0, $past(multis_in_frame)} + 24'd1))
    else $error("frame counts grew by more than one");

endmodule

@@ rtl/dfs_out_reg.sv @@
// dfs_out_reg: result register holding up to two records of one pixel
// depends on dfs_pkg; photon record goes out before the frame summary

module dfs_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  dfs_pkg::rec_t                rec_in,
  input  logic                         src_valid,
  output logic                         load_ok,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dfs_pkg::KIND_W-1:0]   record_kind,
  output logic [dfs_pkg::IDX_W-1:0]    pixel_index,
  output logic [dfs_pkg::CNT_W-1:0]    photon_count,
  output logic [dfs_pkg::ADDR_W-1:0]   list_address,
  output logic [dfs_pkg::FCNT_W-1:0]   frame_singles,
  output logic [dfs_pkg::FCNT_W-1:0]   frame_multis,
  output logic [dfs_pkg::ADDR_W-1:0]   next_single_offset,
  output logic [dfs_pkg::ADDR_W-1:0]   next_multi_offset,
  output logic                         last_of_run
);
  import dfs_pkg::*;

  rec_t rec;
  logic ph_pend;
  logic sum_pend;
  logic take;
  logic take_last;
  logic load;

  // one transaction leaves per cycle while out_stall is low; refill when empty or when the last one goes
  assign out_valid = ph_pend || sum_pend;
  assign take      = out_valid && !out_stall;
  assign take_last = take && !(ph_pend && sum_pend);
  assign load_ok   = !out_valid || take_last;
  assign load      = src_valid && load_ok;

  // pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ph_pend  <= 1'b0;
      sum_pend <= 1'b0;
    end else if (load) begin
      ph_pend  <= rec_in.has_photon;
      sum_pend <= rec_in.has_summary;
    end else if (take) begin
      if (ph_pend) begin
        ph_pend <= 1'b0;
      end else begin
        sum_pend <= 1'b0;
      end
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

  // output select
  always_comb begin
    if (ph_pend) begin
      record_kind        = rec.is_multi ? KIND_MULTI : KIND_SINGLE;
      pixel_index        = rec.pixel_index;
      photon_count       = rec.is_multi ? rec.photon_count : {{(CNT_W-1){1'b0}}, 1'b1};
      list_address       = rec.list_address;
      frame_singles      = '0;
      frame_multis       = '0;
      next_single_offset = '0;
      next_multi_offset  = '0;
      last_of_run        = !sum_pend;
    end else begin
      record_kind        = KIND_SUMMARY;
      pixel_index        = '0;
      photon_count       = '0;
      list_address       = '0;
      frame_singles      = rec.frame_singles;
      frame_multis       = rec.frame_multis;
      next_single_offset = rec.next_single_offset;
      next_multi_offset  = rec.next_multi_offset;
      last_of_run        = 1'b1;
    end
  end

  // taking the photon record of a pair leaves only the summary
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    take && ph_pend && sum_pend |=> sum_pend && !ph_pend)
    else $error("record pair drained out of order");

  // a summary always closes its run
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_SUMMARY |-> last_of_run)
    else $error("summary record not marked last");

endmodule
